@@ sv/sts_pkg.sv @@
package sts_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;

    // field widths of one item
    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int CNT_W = 11;

    // stream packing, lowest field first, padded to whole bytes
    localparam int LOAD_INDEX_LSB = 0;
    localparam int LOAD_VALUE_LSB = LOAD_INDEX_LSB + IDX_W;
    localparam int SEARCH_KEY_LSB = LOAD_VALUE_LSB + VAL_W;
    localparam int IN_FIELDS_W    = SEARCH_KEY_LSB + VAL_W;
    localparam int IN_TDATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W    = ((IDX_W + 1 + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = CNT_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ELEMENT_COUNT = 1'b0,
        CFG_SEARCH_MODE   = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        REQ_LOAD   = 1'b0,
        REQ_SEARCH = 1'b1
    } t_req;

    typedef enum logic {
        MODE_THREE_WAY   = 1'b0,
        MODE_SINGLE_TEST = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0] position;
        logic             found;
    } t_result;

endpackage

@@ sv/sts_table.sv @@
module sts_table #(
    parameter int TABLE_DEPTH = sts_pkg::DEF_TABLE_DEPTH,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [AW-1:0]                    i_waddr,
    input  logic signed [sts_pkg::VAL_W-1:0] i_wdata,
    input  logic [AW-1:0]                    i_raddr,
    output logic signed [sts_pkg::VAL_W-1:0] o_rdata
);
    import sts_pkg::*;

    logic signed [VAL_W-1:0] r_mem [TABLE_DEPTH];
    logic signed [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/sts_engine.sv @@
module sts_engine #(
    parameter int TABLE_DEPTH = sts_pkg::DEF_TABLE_DEPTH,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_item_valid,
    output logic                             o_item_ready,
    input  sts_pkg::t_req                    i_req,
    input  logic [sts_pkg::IDX_W-1:0]        i_load_index,
    input  logic signed [sts_pkg::VAL_W-1:0] i_load_value,
    input  logic signed [sts_pkg::VAL_W-1:0] i_search_key,
    input  logic [sts_pkg::CNT_W-1:0]        i_element_count,
    input  sts_pkg::t_mode                   i_search_mode,
    output logic                             o_res_valid,
    output sts_pkg::t_result                 o_res,
    input  logic                             i_res_take,
    output logic                             o_tbl_we,
    output logic [AW-1:0]                    o_tbl_waddr,
    output logic signed [sts_pkg::VAL_W-1:0] o_tbl_wdata,
    output logic [AW-1:0]                    o_tbl_raddr,
    input  logic signed [sts_pkg::VAL_W-1:0] i_tbl_rdata
);
    import sts_pkg::*;

    // signed bounds: low reaches the count, high drops to minus one
    localparam int SW = AW + 2;
    localparam logic signed [SW-1:0] ZERO_S  = '0;
    localparam logic signed [SW-1:0] ONE_S   = SW'(1);
    localparam logic signed [SW-1:0] DEPTH_S = SW'(TABLE_DEPTH);

    t_state r_state, n_state;

    logic signed [VAL_W-1:0] r_key;
    logic signed [SW-1:0]    r_lo, r_hi, r_mid;
    t_result                 r_res;

    logic signed [SW-1:0] w_n, w_init_hi, w_init_mid;
    logic signed [SW-1:0] n_lo, n_hi, n_mid;
    logic                 w_lt, w_eq, w_finish;
    t_result              w_res;

    // midpoint truncated toward zero; only a sum of minus one goes negative
    function automatic logic signed [SW-1:0] f_mid(input logic signed [SW-1:0] a,
                                                   input logic signed [SW-1:0] b);
        logic signed [SW-1:0] s;
        s = a + b;
        if (s[SW-1]) begin
            f_mid = ZERO_S;
        end else begin
            f_mid = s >>> 1;
        end
    endfunction

    always_comb begin
        if (int'(i_element_count) > TABLE_DEPTH) begin
            w_n = DEPTH_S;
        end else begin
            w_n = SW'(i_element_count);
        end
        w_init_hi  = w_n - ONE_S;
        w_init_mid = f_mid(ZERO_S, w_init_hi);
    end

    // shared compare unit, one probe per cycle
    always_comb begin
        w_lt = r_key < i_tbl_rdata;
        w_eq = r_key == i_tbl_rdata;
        n_lo = r_lo;
        n_hi = r_hi;
        if (w_lt) begin
            n_hi = r_mid - ONE_S;
        end else begin
            n_lo = r_mid + ONE_S;
        end
        n_mid = f_mid(n_lo, n_hi);
        if (i_search_mode == MODE_SINGLE_TEST) begin
            w_finish = w_eq || !(r_lo < r_hi);
        end else begin
            w_finish = w_eq || !(n_lo <= n_hi);
        end
        w_res.found    = w_eq;
        w_res.position = w_eq ? IDX_W'(r_mid) : '0;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid && i_req == REQ_SEARCH) begin
                    n_state = (w_n == ZERO_S) ? S_DONE : S_PROBE;
                end
            end
            S_PROBE: begin
                if (w_finish) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_item_ready = (r_state == S_IDLE);
        o_res_valid  = (r_state == S_DONE);
        o_res        = r_res;
        o_tbl_we     = (r_state == S_IDLE) && i_item_valid && (i_req == REQ_LOAD)
                       && (int'(i_load_index) < TABLE_DEPTH);
        o_tbl_waddr  = AW'(i_load_index);
        o_tbl_wdata  = i_load_value;
        // next probe address goes straight to the read port
        o_tbl_raddr  = (r_state == S_PROBE) ? n_mid[AW-1:0] : w_init_mid[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_item_valid) begin
            r_key <= i_search_key;
            r_lo  <= ZERO_S;
            r_hi  <= w_init_hi;
            r_mid <= w_init_mid;
            r_res <= '0;
        end else if (r_state == S_PROBE) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_mid <= n_mid;
            r_res <= w_res;
        end
    end

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_mid >= ZERO_S) && (r_mid < DEPTH_S))
        else $error("probe address outside the table");

    a_bounds_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_lo <= r_hi + ONE_S))
        else $error("search bounds crossed by more than one");

    a_busy_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item_valid && o_item_ready && i_req == REQ_SEARCH) |=> !o_item_ready)
        else $error("ready straight after a search was taken");

    a_miss_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.found) |-> (o_res.position == '0))
        else $error("miss reported with a nonzero position");

    a_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tbl_we |-> (r_state == S_IDLE))
        else $error("table written during a search");

endmodule

@@ sv/sorted_table_binary_search.sv @@
// Searches a table of signed 32-bit values, loaded in ascending order, for a key.
// A load item (tuser 0) writes one entry if its index lies inside the table and
// gives no result; a search item (tuser 1) gives one result. A search is started,
// then probes one entry per cycle, as the table's single registered read port
// returns one entry a cycle, and then passes its result to the output register
// when that register can take it. The table is not cleared at reset, so every
// entry a search can probe must be loaded first; the count is held at the table
// depth if written larger.
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = sts_pkg::DEF_TABLE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // load_index, load_value, search_key, zero pad
    input  logic [sts_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // req_type
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // found, position, zero pad
    output logic [sts_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [sts_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sts_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sts_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [CNT_W-1:0] r_element_count;
    t_mode            r_search_mode;

    logic                    r_m_valid;
    t_result                 r_m_res;

    logic                    w_res_valid, w_res_take;
    t_result                 w_res;
    logic                    w_tbl_we;
    logic [AW-1:0]           w_tbl_waddr, w_tbl_raddr;
    logic signed [VAL_W-1:0] w_tbl_wdata, w_tbl_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_count <= '0;
            r_search_mode   <= MODE_THREE_WAY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ELEMENT_COUNT: r_element_count <= i_cfg_data;
                CFG_SEARCH_MODE:   r_search_mode   <= t_mode'(i_cfg_data[0]);
                default: ;
            endcase
        end
    end

    sts_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (s_axis_tvalid),
        .o_item_ready    (s_axis_tready),
        .i_req           (t_req'(s_axis_tuser)),
        .i_load_index    (s_axis_tdata[LOAD_INDEX_LSB +: IDX_W]),
        .i_load_value    (s_axis_tdata[LOAD_VALUE_LSB +: VAL_W]),
        .i_search_key    (s_axis_tdata[SEARCH_KEY_LSB +: VAL_W]),
        .i_element_count (r_element_count),
        .i_search_mode   (r_search_mode),
        .o_res_valid     (w_res_valid),
        .o_res           (w_res),
        .i_res_take      (w_res_take),
        .o_tbl_we        (w_tbl_we),
        .o_tbl_waddr     (w_tbl_waddr),
        .o_tbl_wdata     (w_tbl_wdata),
        .o_tbl_raddr     (w_tbl_raddr),
        .i_tbl_rdata     (w_tbl_rdata)
    );

    sts_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_tbl_we),
        .i_waddr (w_tbl_waddr),
        .i_wdata (w_tbl_wdata),
        .i_raddr (w_tbl_raddr),
        .o_rdata (w_tbl_rdata)
    );

    // output register frees the engine while a result waits
    assign w_res_take = w_res_valid && (!r_m_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_take) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_m_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - IDX_W - 1){1'b0}}, r_m_res.position, r_m_res.found};

endmodule
